/* sv/qwt_pkg.sv */
// Package for the quoted word tokenizer: payload structs, result kinds,
// character codes and the queue record passed from front to back.
// No dependencies.
package qwt_pkg;

  // Result kinds
  localparam logic [1:0] KIND_CHAR       = 2'd0;
  localparam logic [1:0] KIND_WORD_END   = 2'd1;
  localparam logic [1:0] KIND_LINE_DONE  = 2'd2;
  localparam logic [1:0] KIND_LINE_ERROR = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  // Configuration
  localparam logic [7:0] MAX_TOKENS_RESET = 8'd24;

  typedef struct packed {
    logic [7:0] symbol;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [7:0] word_index;
    logic [7:0] word_count;
    logic       last;
  } out_t;

  // One classified item: its first result and, when two is set, a second
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } rec_t;

endpackage

/* sv/qwt_front.sv */
// Front part of the quoted word tokenizer: accepts characters, keeps the
// quote, escape and word state and turns items that give results into queue records.
// Depends on qwt_pkg.
module qwt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qwt_pkg::in_t  in_data_i,
  input  logic [7:0]    max_tokens_i,
  input  logic          full_i,
  output logic          push_o,
  output qwt_pkg::rec_t rec_o
);

  logic       sq_q, sq_d;
  logic       dq_q, dq_d;
  logic       esc_q, esc_d;
  logic       wo_q, wo_d;
  logic       disc_q, disc_d;
  logic [7:0] wd_q, wd_d;

  logic       accept;
  logic       eol;
  logic       small_limit;
  logic       produce;
  logic [7:0] wd_inc;

  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign eol         = in_data_i.line_end || (in_data_i.symbol == qwt_pkg::CH_NUL);
  assign small_limit = (max_tokens_i < 8'd2);
  assign wd_inc      = wd_q + 8'd1;
  assign push_o      = accept && produce;

  // Classify the item and work out the next line state
  always_comb begin
    sq_d    = sq_q;
    dq_d    = dq_q;
    esc_d   = esc_q;
    wo_d    = wo_q;
    disc_d  = disc_q;
    wd_d    = wd_q;
    produce = 1'b0;
    rec_o   = '0;
    rec_o.r0.last = 1'b1;
    rec_o.r1.last = 1'b1;
    if (eol) begin
      sq_d   = 1'b0;
      dq_d   = 1'b0;
      esc_d  = 1'b0;
      wo_d   = 1'b0;
      disc_d = 1'b0;
      wd_d   = '0;
      if (!disc_q) begin
        produce = 1'b1;
        if (small_limit) begin
          rec_o.r0.kind = qwt_pkg::KIND_LINE_DONE;
        end else if (esc_q || sq_q || dq_q) begin
          rec_o.r0.kind = qwt_pkg::KIND_LINE_ERROR;
        end else if (wo_q) begin
          rec_o.two           = 1'b1;
          rec_o.r0.kind       = qwt_pkg::KIND_WORD_END;
          rec_o.r0.word_index = wd_q;
          rec_o.r0.last       = 1'b0;
          rec_o.r1.kind       = qwt_pkg::KIND_LINE_DONE;
          rec_o.r1.word_count = wd_inc;
        end else begin
          rec_o.r0.kind       = qwt_pkg::KIND_LINE_DONE;
          rec_o.r0.word_count = wd_q;
        end
      end
    end else if (!disc_q && !small_limit) begin
      if (esc_q) begin
        esc_d               = 1'b0;
        wo_d                = 1'b1;
        produce             = 1'b1;
        rec_o.r0.kind       = qwt_pkg::KIND_CHAR;
        rec_o.r0.out_char   = in_data_i.symbol;
        rec_o.r0.word_index = wd_q;
      end else if (in_data_i.symbol == qwt_pkg::CH_BSL && !sq_q) begin
        wo_d  = 1'b1;
        esc_d = 1'b1;
      end else if (in_data_i.symbol == qwt_pkg::CH_SQ && !dq_q) begin
        wo_d = 1'b1;
        sq_d = !sq_q;
      end else if (in_data_i.symbol == qwt_pkg::CH_DQ && !sq_q) begin
        wo_d = 1'b1;
        dq_d = !dq_q;
      end else if (!sq_q && !dq_q && (in_data_i.symbol == qwt_pkg::CH_SPACE ||
                                      in_data_i.symbol == qwt_pkg::CH_TAB)) begin
        // Separator: close an open word, maybe close the line early
        if (wo_q) begin
          wd_d                = wd_inc;
          wo_d                = 1'b0;
          produce             = 1'b1;
          rec_o.r0.kind       = qwt_pkg::KIND_WORD_END;
          rec_o.r0.word_index = wd_q;
          if (wd_inc >= (max_tokens_i - 8'd1)) begin
            disc_d              = 1'b1;
            rec_o.two           = 1'b1;
            rec_o.r0.last       = 1'b0;
            rec_o.r1.kind       = qwt_pkg::KIND_LINE_DONE;
            rec_o.r1.word_count = wd_inc;
          end
        end
      end else begin
        wo_d                = 1'b1;
        produce             = 1'b1;
        rec_o.r0.kind       = qwt_pkg::KIND_CHAR;
        rec_o.r0.out_char   = in_data_i.symbol;
        rec_o.r0.word_index = wd_q;
      end
    end
  end

  // Advance the line state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= 1'b0;
      dq_q   <= 1'b0;
      esc_q  <= 1'b0;
      wo_q   <= 1'b0;
      disc_q <= 1'b0;
      wd_q   <= '0;
    end else if (accept) begin
      sq_q   <= sq_d;
      dq_q   <= dq_d;
      esc_q  <= esc_d;
      wo_q   <= wo_d;
      disc_q <= disc_d;
      wd_q   <= wd_d;
    end
  end

endmodule

/* sv/qwt_queue.sv */
// Short queue of classified records between the tokenizer front and back.
// Register array with read at the head pointer. Depends on qwt_pkg.
module qwt_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qwt_pkg::rec_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output qwt_pkg::rec_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qwt_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* sv/qwt_back.sv */
// Back part of the quoted word tokenizer: unpacks queue records into one
// result per transfer through an output register. Depends on qwt_pkg.
module qwt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  qwt_pkg::rec_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qwt_pkg::out_t out_data_o
);

  logic          out_valid_q, out_valid_d;
  logic          sec_valid_q, sec_valid_d;
  qwt_pkg::out_t out_q, out_d;
  qwt_pkg::out_t sec_q, sec_d;
  logic          slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = slot_free && !sec_valid_q && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Pick the next result: a pending second result first, then the queue head
  always_comb begin
    out_valid_d = out_valid_q;
    sec_valid_d = sec_valid_q;
    out_d       = out_q;
    sec_d       = sec_q;
    if (slot_free) begin
      if (sec_valid_q) begin
        out_d       = sec_q;
        out_valid_d = 1'b1;
        sec_valid_d = 1'b0;
      end else if (!empty_i) begin
        out_d       = head_i.r0;
        out_valid_d = 1'b1;
        sec_d       = head_i.r1;
        sec_valid_d = head_i.two;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_valid_q <= sec_valid_d;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

endmodule

/* sv/quoted_word_tokenizer.sv */
// Top level of the quoted word tokenizer: configuration register, front,
// record queue and back. Depends on qwt_pkg, qwt_front, qwt_queue, qwt_back.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one line
//   character per transfer, or an end-of-line event (line_end set, or a
//   zero symbol). Output channel (out_valid_o / out_ready_i / out_data_o)
//   carries results: word characters, word ends, line done, line error.
//   cfg_we_i writes max_tokens from cfg_wdata_i; write it only
//   while the block is idle.
// Throughput: one input per cycle unless the queue is full; one result per
//   cycle on the output while out_ready_i is high. An item with two results
//   (word end plus line done) holds the output for both, absorbed by the
//   QueueDepth-entry record queue. A record enters the queue at the
//   input transfer; its first result moves to the output register when free.
// Reset: line state is cleared, the queue and output register are emptied
//   and max_tokens returns to 24.
// Stall: when out_ready_i is low the output register holds; records collect
//   in the queue and in_ready_o drops once the queue is full.
module quoted_word_tokenizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qwt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qwt_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  logic [7:0]    max_tokens_q;
  logic          full, empty, push, pop;
  qwt_pkg::rec_t push_rec, head_rec;

  // Write the max_tokens register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= qwt_pkg::MAX_TOKENS_RESET;
    end else if (cfg_we_i) begin
      max_tokens_q <= cfg_wdata_i;
    end
  end

  qwt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .max_tokens_i(max_tokens_q),
    .full_i      (full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  qwt_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_rec)
  );

  qwt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // Line done and line error always close an item
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == qwt_pkg::KIND_LINE_DONE ||
                    out_data_o.kind == qwt_pkg::KIND_LINE_ERROR) |-> out_data_o.last)
    else $error("line close result without last");

  // A word end that is not last is followed at once by line done
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last &&
    out_data_o.kind == qwt_pkg::KIND_WORD_END
    |=> out_valid_o && out_data_o.kind == qwt_pkg::KIND_LINE_DONE)
    else $error("second result of an item missing");

  // Word characters carry no count and always end their item
  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == qwt_pkg::KIND_CHAR
    |-> out_data_o.last && out_data_o.word_count == 8'd0)
    else $error("malformed word character result");
`endif

endmodule
